// File: hdl/mi3_pkg.sv
// Shared constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps

package mi3_pkg;

	// Default element format: signed Q16.16.
	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;

	// Singularity threshold register, in units of 2^-(3*FRAC_BITS).
	localparam int                   THR_BITS  = 63;
	localparam logic [THR_BITS-1:0] THR_RESET = 63'd28147498;

endpackage

// File: hdl/mi3_cof.sv
// Signed 2x2 cofactors of a 3x3 matrix, two register stages.
`timescale 1ns / 1ps

module mi3_cof #(
	parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [WORD_BITS-1:0]   a   [9],
	output logic signed [2*WORD_BITS:0]   cof [9]
);
	import mi3_pkg::*;

	localparam int W = WORD_BITS;

	logic signed [2*W-1:0] p0_s1 [9];
	logic signed [2*W-1:0] p1_s1 [9];

	// Cofactor (f, c) sits at index 3*f + c. An odd position swaps the two
	// products so that the sign comes for free.
	for (genvar f = 0; f < 3; f++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int R1 = (f == 0) ? 1 : 0;
			localparam int R2 = (f == 2) ? 1 : 2;
			localparam int K1 = (c == 0) ? 1 : 0;
			localparam int K2 = (c == 2) ? 1 : 2;
			localparam int J  = 3 * f + c;
			localparam bit ODD = ((f + c) % 2) == 1;

			always_ff @(posedge clk) begin
				if (en) begin
					if (ODD) begin
						p0_s1[J] <= (2*W)'(a[3*R1+K2]) * (2*W)'(a[3*R2+K1]);
						p1_s1[J] <= (2*W)'(a[3*R1+K1]) * (2*W)'(a[3*R2+K2]);
					end else begin
						p0_s1[J] <= (2*W)'(a[3*R1+K1]) * (2*W)'(a[3*R2+K2]);
						p1_s1[J] <= (2*W)'(a[3*R1+K2]) * (2*W)'(a[3*R2+K1]);
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					cof[J] <= $signed({p0_s1[J][2*W-1], p0_s1[J]})
						- $signed({p1_s1[J][2*W-1], p1_s1[J]});
				end
			end
		end
	end

endmodule

// File: hdl/mi3_det.sv
// Determinant by first-row expansion and its magnitude, four register stages.
`timescale 1ns / 1ps

module mi3_det #(
	parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [WORD_BITS-1:0]   a0   [3],
	input  logic signed [2*WORD_BITS:0]   cof0 [3],
	output logic        [3*WORD_BITS-1:0] adet,
	output logic                          dneg
);
	import mi3_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int DETW = 3 * W + 1;

	logic signed [2*W:0]   ph_s3 [3];
	logic signed [2*W:0]   pl_s3 [3];
	logic        [DETW-1:0] t_s4 [3];
	logic        [DETW-1:0] det_s5;
	logic        [DETW-1:0] det_neg;

	// Each cofactor is split into a signed high half and an unsigned low half
	// so that no multiplier is wider than one element by one element plus one bit.
	for (genvar k = 0; k < 3; k++) begin : g_term
		always_ff @(posedge clk) begin
			if (en) begin
				ph_s3[k] <= (2*W+1)'(a0[k]) * (2*W+1)'($signed(cof0[k][2*W:W]));
				pl_s3[k] <= (2*W+1)'(a0[k])
					* (2*W+1)'($signed({1'b0, cof0[k][W-1:0]}));
				t_s4[k]  <= ({{W{ph_s3[k][2*W]}}, ph_s3[k]} << W)
					+ {{W{pl_s3[k][2*W]}}, pl_s3[k]};
			end
		end
	end

	assign det_neg = ~det_s5 + DETW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			dneg   <= det_s5[DETW-1];
			adet   <= det_s5[DETW-1] ? det_neg[3*W-1:0] : det_s5[3*W-1:0];
		end
	end

endmodule

// File: hdl/mi3_div.sv
// Restoring unsigned divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module mi3_div #(
	parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [((2*WORD_BITS+2*FRAC_BITS+1) > 3*WORD_BITS ?
		(2*WORD_BITS+2*FRAC_BITS+1) : 3*WORD_BITS):0] num,
	input  logic [3*WORD_BITS:0]                   den,
	output logic [WORD_BITS:0]                     quo,
	output logic                                   ovf
);
	import mi3_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NW = ((2*W+2*F+1) > 3*W ? (2*W+2*F+1) : 3*W) + 1;
	localparam int QB = W + 1;
	localparam int DW = 3 * W + 1;
	localparam int RW = (NW > DW + QB) ? NW : DW + QB;

	logic [RW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];

	// The quotient keeps QB bits; anything at or above 2^QB is flagged here
	// and saturated downstream.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= RW'(num) >= (RW'(den) << QB);
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_step
		localparam int B = QB - i;
		logic [RW-1:0] dsh;
		logic          ge;

		assign dsh = RW'(den_s[i-1]) << B;
		assign ge  = rem_s[i-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= {quo_s[i-1][QB-2:0], ge};
				ovf_s[i] <= ovf_s[i-1];
			end
		end

		if (i < QB) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? rem_s[i-1] - dsh : rem_s[i-1];
					den_s[i] <= den_s[i-1];
				end
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// File: hdl/matrix_inverse_3x3.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
//
// Input channel: in_valid with the nine elements a00..a22 (signed, row by
// row); an item is taken at a rising edge where in_valid is high and in_stall
// is low. Output channel: out_valid with b00..b22, singular and overflow;
// the receiver takes an item where out_valid is high and out_stall is low.
// Each item is one matrix and gives exactly one result item.
// The pipeline runs through the 2x2 cofactors, the determinant, the register
// that forms the dividend, the nine bit-serial divider pipelines and one
// output register; elements default to the signed Q16.16 format.
// Throughput is one item per clock as long as the receiver keeps taking.
// The whole pipeline moves together: when a result sits in the output
// register and out_stall is high, every stage holds and in_stall goes high,
// so nothing is lost or repeated. Empty stages hold as well; a bubble is
// never squeezed out while the output waits.
// Reset clears all valid bits and loads the singularity threshold with its
// default; payload registers are not reset. The threshold is written through
// cfg_we/cfg_wdata and should only change while no item is in flight.
// A matrix whose absolute determinant is at or below the threshold gives all
// zero elements with singular set; overflow marks a saturated element.

module matrix_inverse_3x3 #(
	parameter int WORD_BITS = mi3_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mi3_pkg::THR_BITS-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [WORD_BITS-1:0]    a00,
	input  logic signed [WORD_BITS-1:0]    a01,
	input  logic signed [WORD_BITS-1:0]    a02,
	input  logic signed [WORD_BITS-1:0]    a10,
	input  logic signed [WORD_BITS-1:0]    a11,
	input  logic signed [WORD_BITS-1:0]    a12,
	input  logic signed [WORD_BITS-1:0]    a20,
	input  logic signed [WORD_BITS-1:0]    a21,
	input  logic signed [WORD_BITS-1:0]    a22,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [WORD_BITS-1:0]    b00,
	output logic signed [WORD_BITS-1:0]    b01,
	output logic signed [WORD_BITS-1:0]    b02,
	output logic signed [WORD_BITS-1:0]    b10,
	output logic signed [WORD_BITS-1:0]    b11,
	output logic signed [WORD_BITS-1:0]    b12,
	output logic signed [WORD_BITS-1:0]    b20,
	output logic signed [WORD_BITS-1:0]    b21,
	output logic signed [WORD_BITS-1:0]    b22,
	output logic                           singular,
	output logic                           overflow
);
	import mi3_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int NW   = ((2*W+2*F+1) > 3*W ? (2*W+2*F+1) : 3*W) + 1;
	localparam int QB   = W + 1;
	localparam int CW   = (3*W > THR_BITS) ? 3*W : THR_BITS;
	localparam int DLAT = W + 2;
	localparam int LAT  = W + 10;

	localparam logic [QB-1:0] MAXP = {2'b00, {(W-1){1'b1}}};
	localparam logic [QB-1:0] MAXN = {2'b01, {(W-1){1'b0}}};

	logic [THR_BITS-1:0] thr_q;
	logic [LAT-1:0]      valid_q;
	logic                adv;

	logic signed [W-1:0]   a_in     [9];
	logic signed [W-1:0]   a_row_s1 [3];
	logic signed [W-1:0]   a_row_s2 [3];
	logic signed [2*W:0]   cof_s2   [9];
	logic signed [2*W:0]   cof_row  [3];
	logic        [3*W-1:0] adet_s6;
	logic                  dneg_s6;

	logic [2*W-1:0] acof_s3 [9];
	logic [2*W-1:0] acof_s4 [9];
	logic [2*W-1:0] acof_s5 [9];
	logic [2*W-1:0] acof_s6 [9];
	logic [8:0]     cneg_s3;
	logic [8:0]     cneg_s4;
	logic [8:0]     cneg_s5;
	logic [8:0]     cneg_s6;

	logic [NW-1:0]  num_s7 [9];
	logic [3*W:0]   den_s7;
	logic [8:0]     neg_s7;
	logic           sing_s7;

	// Sign and singular flag wait here while the dividers work.
	logic [9:0]     side_s8 [DLAT];

	logic [QB-1:0]  quo     [9];
	logic [8:0]     dovf;
	logic [W-1:0]   res     [9];
	logic [8:0]     sat;
	logic [W-1:0]   res_q   [9];

	// All stages advance together unless a finished result is held.
	assign adv       = !(valid_q[LAT-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[LAT-2:0], in_valid};
		end
	end

	assign a_in[0] = a00;
	assign a_in[1] = a01;
	assign a_in[2] = a02;
	assign a_in[3] = a10;
	assign a_in[4] = a11;
	assign a_in[5] = a12;
	assign a_in[6] = a20;
	assign a_in[7] = a21;
	assign a_in[8] = a22;

	mi3_cof #(.WORD_BITS(W)) u_cof (
		.clk (clk),
		.en  (adv),
		.a   (a_in),
		.cof (cof_s2)
	);

	// The first row rides along so that it meets its cofactors.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_row_s1[k] <= a_in[k];
				a_row_s2[k] <= a_row_s1[k];
			end
		end
	end

	// Cofactors (0,0), (0,1) and (0,2) expand the determinant along row 0.
	assign cof_row[0] = cof_s2[0];
	assign cof_row[1] = cof_s2[1];
	assign cof_row[2] = cof_s2[2];

	mi3_det #(.WORD_BITS(W)) u_det (
		.clk  (clk),
		.en   (adv),
		.a0   (a_row_s2),
		.cof0 (cof_row),
		.adet (adet_s6),
		.dneg (dneg_s6)
	);

	// Cofactor magnitudes and signs, delayed to line up with the determinant.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				acof_s3[k] <= cof_s2[k][2*W] ? (2*W)'(-cof_s2[k]) : cof_s2[k][2*W-1:0];
				cneg_s3[k] <= cof_s2[k][2*W];
				acof_s4[k] <= acof_s3[k];
				acof_s5[k] <= acof_s4[k];
				acof_s6[k] <= acof_s5[k];
			end
			cneg_s4 <= cneg_s3;
			cneg_s5 <= cneg_s4;
			cneg_s6 <= cneg_s5;
		end
	end

	// Rounded quotient: (|cof| * 2^(2F+1) + |det|) / (2 * |det|), which rounds
	// half away from zero once the sign is put back.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				num_s7[k] <= NW'({acof_s6[k], {(2*F+1){1'b0}}}) + NW'(adet_s6);
				neg_s7[k] <= cneg_s6[k] ^ dneg_s6;
			end
			den_s7  <= {adet_s6, 1'b0};
			sing_s7 <= CW'(adet_s6) <= CW'(thr_q);
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_div
		mi3_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s7[k]),
			.den (den_s7),
			.quo (quo[k]),
			.ovf (dovf[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8[0] <= {sing_s7, neg_s7};
			for (int i = 1; i < DLAT; i++) begin
				side_s8[i] <= side_s8[i-1];
			end
		end
	end

	// Put the sign back and clamp to the word range.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			if (side_s8[DLAT-1][k]) begin
				sat[k] = dovf[k] || (quo[k] > MAXN);
				res[k] = sat[k] ? MAXN[W-1:0] : (~quo[k][W-1:0] + W'(1));
			end else begin
				sat[k] = dovf[k] || (quo[k] > MAXP);
				res[k] = sat[k] ? MAXP[W-1:0] : quo[k][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				res_q[k] <= side_s8[DLAT-1][9] ? '0 : res[k];
			end
			singular <= side_s8[DLAT-1][9];
			overflow <= !side_s8[DLAT-1][9] && (sat != '0);
		end
	end

	// Divider 3*f + c holds cofactor (f, c), which is inverse element (c, f).
	assign b00 = res_q[0];
	assign b01 = res_q[3];
	assign b02 = res_q[6];
	assign b10 = res_q[1];
	assign b11 = res_q[4];
	assign b12 = res_q[7];
	assign b20 = res_q[2];
	assign b21 = res_q[5];
	assign b22 = res_q[8];

endmodule

// File: verif/matrix_inverse_3x3_test.sv
// Testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;
	import mi3_pkg::*;

	localparam int WB = DEF_WORD_BITS;
	localparam int FB = DEF_FRAC_BITS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// One matrix and one inverse, element index is row * 3 + column.
	typedef struct packed {
		logic [8:0][WB-1:0] a;
	} matrix_t;

	typedef struct packed {
		logic [8:0][WB-1:0] b;
		logic               singular;
		logic               overflow;
	} inverse_t;

	// The scoreboard keeps its own copy of the threshold and a queue of the
	// inverses that the block still owes us, oldest first.
	class inverse_scoreboard;
		logic [THR_BITS-1:0] threshold;
		inverse_t            owed[$];
		int                  mismatches;
		int                  matrices;
		int                  singulars;
		int                  overflows;

		function new();
			threshold = THR_RESET;
			mismatches = 0;
			matrices = 0;
			singulars = 0;
			overflows = 0;
		endfunction

		// Exact adjugate over determinant, rounded half away from zero and
		// saturated to the word width.
		function inverse_t invert(matrix_t m);
			logic signed [127:0] e[9];
			logic signed [127:0] det, cof;
			logic [127:0]        adet, acof;
			logic [191:0]        num, q;
			logic [WB-1:0]       mag;
			logic signed [127:0] s[4];
			logic                dneg, cneg, neg;
			inverse_t            r;
			int                  n;
			for (int i = 0; i < 9; i++)
				e[i] = 128'($signed(m.a[i]));
			det = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[3] * e[7] * e[2]
				- e[6] * e[4] * e[2] - e[3] * e[1] * e[8] - e[5] * e[7] * e[0];
			dneg = det < 0;
			adet = dneg ? -det : det;
			r = '0;
			if (adet <= {65'd0, threshold}) begin
				r.singular = 1'b1;
				return r;
			end
			for (int f = 0; f < 3; f++) begin
				for (int c = 0; c < 3; c++) begin
					n = 0;
					for (int rr = 0; rr < 3; rr++) begin
						for (int k = 0; k < 3; k++) begin
							if (rr != f && k != c) begin
								s[n] = e[3 * rr + k];
								n++;
							end
						end
					end
					cof = s[0] * s[3] - s[1] * s[2];
					if ((f + c) % 2 == 1)
						cof = -cof;
					cneg = cof < 0;
					acof = cneg ? -cof : cof;
					num = ({64'd0, acof} << (2 * FB + 1)) + {64'd0, adet};
					q = num / ({64'd0, adet} << 1);
					neg = cneg != dneg;
					if (!neg && q > (192'd1 << (WB - 1)) - 1) begin
						q = (192'd1 << (WB - 1)) - 1;
						r.overflow = 1'b1;
					end else if (neg && q > (192'd1 << (WB - 1))) begin
						q = 192'd1 << (WB - 1);
						r.overflow = 1'b1;
					end
					mag = q[WB-1:0];
					r.b[c * 3 + f] = neg ? -mag : mag;
				end
			end
			return r;
		endfunction

		function void note_matrix(matrix_t m);
			owed.push_back(invert(m));
			matrices++;
		endfunction

		function void check_inverse(inverse_t got);
			inverse_t want;
			logic     bad;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result arrived with none expected");
				return;
			end
			want = owed.pop_front();
			if (want.singular)
				singulars++;
			if (want.overflow)
				overflows++;
			bad = (want.singular !== got.singular) || (want.overflow !== got.overflow);
			for (int i = 0; i < 9; i++)
				if (want.b[i] !== got.b[i])
					bad = 1'b1;
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR: inverse mismatch, singular %0b/%0b overflow %0b/%0b",
						want.singular, got.singular, want.overflow, got.overflow);
					for (int i = 0; i < 9; i++)
						$display("  b%0d%0d expected %h got %h", i / 3, i % 3,
							want.b[i], got.b[i]);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [THR_BITS-1:0]     cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [WB-1:0]    a00, a01, a02, a10, a11, a12, a20, a21, a22;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [WB-1:0]    b00, b01, b02, b10, b11, b12, b20, b21, b22;
	logic                    singular;
	logic                    overflow;

	inverse_scoreboard sb = new();

	matrix_inverse_3x3 u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
		.a20(a20), .a21(a21), .a22(a22),
		.out_valid(out_valid), .out_stall(out_stall),
		.b00(b00), .b01(b01), .b02(b02), .b10(b10), .b11(b11), .b12(b12),
		.b20(b20), .b21(b21), .b22(b22),
		.singular(singular), .overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Every input starts at a known value while reset is held low.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		{a00, a01, a02, a10, a11, a12, a20, a21, a22} = '0;
		out_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// A hard cycle limit guards against a hung pipeline.
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver. The stall pattern steps in turn through no stall, light random,
	// periodic and heavy random. A long hold-off is requested by bumping
	// hold_seq; this process alone counts it down, while the sender keeps
	// offering items so the pipeline fills and stalls its input.
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_seq != hold_seen) begin
				hold_seen <= hold_seq;
				hold_left <= 300;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				case ((cycles / 256) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= (cycles % 3 == 0);
					default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	// Results are sampled mid-cycle, where nothing is changing, and taken at
	// the following rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_inverse({{b22, b21, b20, b12, b11, b10, b02, b01, b00},
				singular, overflow});
	end

	// Sender bursts: once a burst runs out, the valid may drop for a gap.
	int burst_left = 0;

	task automatic send_matrix(matrix_t m);
		logic taken;
		int   gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		{a22, a21, a20, a12, a11, a10, a02, a01, a00} <= m.a;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sb.note_matrix(m);
	endtask

	// Drains the pipeline before a register write; every item gives a
	// result, so an empty queue means the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_threshold(logic [THR_BITS-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = value;
	endtask

	function automatic matrix_t diagonal(logic [WB-1:0] d0, logic [WB-1:0] d1,
			logic [WB-1:0] d2);
		matrix_t m;
		m = '0;
		m.a[0] = d0;
		m.a[4] = d1;
		m.a[8] = d2;
		return m;
	endfunction

	function automatic logic [WB-1:0] small_value(int span);
		return WB'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// The largest share of random matrices are near unit scale so that inverses
	// are meaningful; the rest are full-width noise, nearly rank-deficient
	// matrices, tiny ones around the threshold and full-width diagonals.
	function automatic matrix_t random_matrix();
		matrix_t m;
		int      pick;
		pick = $urandom_range(0, 99);
		for (int i = 0; i < 9; i++)
			m.a[i] = small_value(1 << 18);
		if (pick < 20) begin
			for (int i = 0; i < 9; i++)
				m.a[i] = $urandom;
		end else if (pick < 35) begin
			for (int i = 0; i < 3; i++)
				m.a[6 + i] = m.a[i] + m.a[3 + i] + $urandom_range(0, 2) - 1;
		end else if (pick < 50) begin
			for (int i = 0; i < 9; i++)
				m.a[i] = small_value($urandom_range(0, 1) ? 400 : 40);
		end else if (pick < 60) begin
			m = diagonal($urandom, $urandom, $urandom);
			m.a[$urandom_range(0, 8)] = $urandom;
		end
		return m;
	endfunction

	task automatic random_run(int count);
		for (int i = 0; i < count; i++)
			send_matrix(random_matrix());
	endtask

	localparam logic [WB-1:0] ONE = 1 << FB;
	localparam logic [WB-1:0] MAXP = {1'b0, {(WB-1){1'b1}}};
	localparam logic [WB-1:0] MAXN = {1'b1, {(WB-1){1'b0}}};

	initial begin
		matrix_t m;
		int      waited;
		@(posedge arst_n);
		@(posedge clk);

		// Directed cases under the reset threshold: identity, the zero matrix,
		// extreme elements, a determinant at and just above the threshold,
		// a rank-deficient matrix, and a full permutation with signs.
		send_matrix(diagonal(ONE, ONE, ONE));
		send_matrix('0);
		send_matrix(diagonal(MAXP, MAXP, MAXP));
		send_matrix(diagonal(MAXN, MAXN, MAXN));
		send_matrix(diagonal(MAXN, MAXP, -ONE));
		send_matrix(diagonal(32'h400, 32'h400, 32'h400));
		send_matrix(diagonal(32'h100, 32'h100, 32'h100));
		send_matrix(diagonal(32'd1, 32'd1, 32'd28147498));
		send_matrix(diagonal(32'd1, 32'd1, 32'd28147499));
		m = '0;
		for (int i = 0; i < 9; i++)
			m.a[i] = MAXN;
		send_matrix(m);
		for (int i = 0; i < 9; i++)
			m.a[i] = ONE * (i + 1);
		send_matrix(m);
		m = '0;
		m.a[1] = -ONE;
		m.a[5] = 3 * ONE;
		m.a[6] = ONE / 2;
		send_matrix(m);
		send_matrix(diagonal(3 * ONE, 3 * ONE, 3 * ONE));
		send_matrix(diagonal(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));

		// With no threshold, a determinant of one least step saturates both ways.
		set_threshold('0);
		send_matrix(diagonal(32'd1, 32'd1, 32'd1));
		send_matrix(diagonal(-32'd1, 32'd1, 32'd1));
		send_matrix(diagonal(32'd2, 32'd3, 32'd7));
		send_matrix('0);

		// The largest threshold makes singular every matrix whose absolute determinant fits in 63 bits.
		set_threshold({THR_BITS{1'b1}});
		send_matrix(diagonal(MAXN, MAXN, MAXN));
		random_run(60);

		// Random phases across several thresholds, with the long receiver
		// hold-off in the middle of the reset-value phase.
		set_threshold(THR_RESET);
		random_run(300);
		hold_seq++;
		random_run(300);
		set_threshold('0);
		random_run(300);
		set_threshold(THR_BITS'({$urandom, $urandom} >> $urandom_range(1, 40)));
		random_run(300);
		set_threshold(63'd1 << 48);
		random_run(300);
		set_threshold(63'd1000000);
		random_run(120);

		in_valid <= 1'b0;
		waited = 0;
		while (sb.owed.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);

		$display("Checked %0d matrices under six different thresholds: %0d singular, %0d saturated.",
			sb.matrices, sb.singulars, sb.overflows);
		$display("Mismatches: %0d, results still owed: %0d", sb.mismatches, sb.owed.size());
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/mi3_pkg.sv
hdl/mi3_cof.sv
hdl/mi3_det.sv
hdl/mi3_div.sv
hdl/matrix_inverse_3x3.sv
verif/matrix_inverse_3x3_test.sv
